FILE: rtl/core/plbq_pkg.sv
// types shared by the price level book: price and quantity words, cell neighbor
// bundle and cell command, per-side control and status groups
// no dependencies
package plbq_pkg;

    localparam int PRICE_W = 64;
    localparam int QTY_W   = 64;

    typedef logic signed [PRICE_W-1:0] t_price;
    typedef logic        [QTY_W-1:0]   t_qty;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   gt;      // cell is empty or holds a price above the probe
        t_price price;
    } t_cell_nb;

    // broadcast to every cell of one side
    typedef struct packed {
        logic   cmp;
        logic   ins;
        logic   del;
        t_price price;
    } t_cell_cmd;

    // sequencer to one side
    typedef struct packed {
        logic   cmp_en;
        logic   upd_en;
        logic   sel_en;
        logic   qty_zero;
        t_price price;
    } t_side_ctrl;

    // one side back to the sequencer
    typedef struct packed {
        logic   drop;
        logic   present;
        t_price lo;
        t_price hi;
    } t_side_stat;

endpackage

FILE: rtl/core/plbq_if.sv
// valid/ready channels for the price level book: update beats in, quote beats out
// depends on plbq_pkg
interface plbq_in_if;
    import plbq_pkg::*;
    logic   valid;
    logic   ready;
    logic   side;
    t_price price;
    t_qty   quantity;

    modport source (output valid, side, price, quantity, input ready);
    modport sink   (input valid, side, price, quantity, output ready);
endinterface

interface plbq_out_if;
    import plbq_pkg::*;
    logic   valid;
    logic   ready;
    logic   bid_present;
    t_price top_bid;
    logic   ask_present;
    t_price top_ask;
    logic   plausible;
    logic   dropped_full;

    modport source (output valid, bid_present, top_bid, ask_present, top_ask,
                    plausible, dropped_full, input ready);
    modport sink   (input valid, bid_present, top_bid, ask_present, top_ask,
                    plausible, dropped_full, output ready);
endinterface

FILE: rtl/core/plbq_cell.sv
// one cell of a sorted price chain: holds one level, compares against the
// probe price and shifts left or right with its neighbors
// depends on plbq_pkg
module plbq_cell import plbq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_cell_nb  i_left,
    input  t_cell_nb  i_right,
    output t_cell_nb  o_own,
    output logic      o_eq
);

    logic   r_valid, n_valid;
    t_price r_price, n_price;
    logic   r_gt, r_ge, r_eq;

    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        if (i_cmd.ins && r_gt) begin
            // open a gap: the first cell above the probe takes the new price
            if (i_left.gt) begin
                n_valid = i_left.valid;
                n_price = i_left.price;
            end else begin
                n_valid = 1'b1;
                n_price = i_cmd.price;
            end
        end else if (i_cmd.del && r_ge) begin
            // close the gap from the matching cell onward
            n_valid = i_right.valid;
            n_price = i_right.price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        if (i_cmd.cmp) begin
            r_gt <= !r_valid || ($signed(r_price) >  $signed(i_cmd.price));
            r_ge <= !r_valid || ($signed(r_price) >= $signed(i_cmd.price));
            r_eq <= r_valid && (r_price == i_cmd.price);
        end
    end

    assign o_own = '{valid: r_valid, gt: r_gt, price: r_price};
    assign o_eq  = r_eq;

endmodule

FILE: rtl/core/plbq_side.sv
// one book side: a chain of cells kept sorted ascending and packed at the
// low end, plus the level count and the lowest/highest price registers
// depends on plbq_pkg, plbq_cell
module plbq_side import plbq_pkg::*; #(
    parameter int LEVELS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_side_ctrl i_ctrl,
    output t_side_stat o_stat
);

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);

    t_cell_nb          w_nb [LEVELS];
    logic [LEVELS-1:0] w_eq;
    t_cell_cmd         w_cmd;
    logic              w_match, w_full, w_ins, w_del;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     w_last;
    logic              r_drop, r_present;
    t_price            r_lo, r_hi;

    assign w_match = |w_eq;
    assign w_full  = w_nb[LEVELS-1].valid;
    assign w_ins   = i_ctrl.upd_en && !w_match && !i_ctrl.qty_zero && !w_full;
    assign w_del   = i_ctrl.upd_en && w_match && i_ctrl.qty_zero;
    assign w_cmd   = '{cmp: i_ctrl.cmp_en, ins: w_ins, del: w_del, price: i_ctrl.price};

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        t_cell_nb w_left, w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_nb[g-1];
        end
        if (g == LEVELS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_nb[g+1];
        end
        plbq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_own   (w_nb[g]),
            .o_eq    (w_eq[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_last = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_present <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.cmp_en) begin
                r_drop <= 1'b0;
            end else if (i_ctrl.upd_en) begin
                r_drop <= !w_match && !i_ctrl.qty_zero && w_full;
            end
            if (i_ctrl.sel_en) begin
                r_present <= w_nb[0].valid;
            end
        end
    end

    // head of the chain is the lowest price, the last used cell the highest
    always_ff @(posedge i_clk) begin
        if (i_ctrl.sel_en) begin
            r_lo <= w_nb[0].valid ? w_nb[0].price : '0;
            r_hi <= w_nb[0].valid ? w_nb[w_last[IW-1:0]].price : '0;
        end
    end

    assign o_stat = '{drop: r_drop, present: r_present, lo: r_lo, hi: r_hi};

endmodule

FILE: rtl/core/price_level_book_best_quote_top.sv
// price level book top: update sequencer, two sorted cell chains, quote register
// depends on plbq_pkg, plbq_if, plbq_side
//
// usage
//   i_in carries update beats (side, price, quantity). quantity zero removes
//   the level at that price; any other quantity sets or inserts it. a new
//   level on a side that already holds LEVELS_PER_SIDE levels is refused and
//   the quote beat carries dropped_full.
//   o_out carries one quote beat per update: best bid/ask with presence
//   flags (price zero when absent) and plausible (not crossed).
//   i_cfg_wr_en/i_cfg_wr_data write the book orientation bit; change it only
//   while idle.
// timing
//   one update at a time. after an accepted beat the block compares the probe
//   price in every cell, then shifts the chain, then picks the lowest/highest
//   cell and then loads the output register, each step a state of its own; a
//   new beat is taken only once the quote is loaded. the highest-price pick is
//   a read of the chain at the last used cell (level count minus one).
//   the output register lets the next beat be accepted while a quote waits;
//   a stalled receiver holds the quote and the block waits before loading.
// reset
//   synchronous active low: both sides empty, orientation bit 0 (normal
//   book), no quote pending.
module price_level_book_best_quote_top import plbq_pkg::*; #(
    parameter int LEVELS_PER_SIDE = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr_en,
    input  logic  i_cfg_wr_data,
    plbq_in_if.sink    i_in,
    plbq_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_UPD  = 5'b00100,
        S_SEL  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic       r_inverted;
    logic       r_side, r_qty_zero;
    t_price     r_price;
    t_side_ctrl w_bid_ctrl, w_ask_ctrl;
    t_side_stat w_bid_stat, w_ask_stat;
    logic       w_in_beat, w_load;
    t_price     w_top_bid, w_top_ask;
    logic       w_plausible;

    // output register
    logic       r_out_valid;
    logic       r_bid_present, r_ask_present, r_plausible, r_dropped;
    t_price     r_top_bid, r_top_ask;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_PUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) n_state = S_CMP;
            end
            S_CMP:  n_state = S_UPD;
            S_UPD:  n_state = S_SEL;
            S_SEL:  n_state = S_PUT;
            S_PUT: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inverted  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_inverted <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // update beat held for the whole pass; only zero/nonzero of the
    // quantity matters to the quote
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_side     <= i_in.side;
            r_price    <= i_in.price;
            r_qty_zero <= (i_in.quantity == '0);
        end
    end

    always_comb begin
        w_bid_ctrl = '{cmp_en: (r_state == S_CMP),
                       upd_en: (r_state == S_UPD) && !r_side,
                       sel_en: (r_state == S_SEL),
                       qty_zero: r_qty_zero,
                       price: r_price};
        w_ask_ctrl = w_bid_ctrl;
        w_ask_ctrl.upd_en = (r_state == S_UPD) && r_side;
    end

    plbq_side #(.LEVELS(LEVELS_PER_SIDE)) u_bid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_bid_ctrl),
        .o_stat  (w_bid_stat)
    );

    plbq_side #(.LEVELS(LEVELS_PER_SIDE)) u_ask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ask_ctrl),
        .o_stat  (w_ask_stat)
    );

    // normal book: best bid is highest, best ask lowest; inverted flips both
    assign w_top_bid = r_inverted ? w_bid_stat.lo : w_bid_stat.hi;
    assign w_top_ask = r_inverted ? w_ask_stat.hi : w_ask_stat.lo;

    always_comb begin
        if (!w_bid_stat.present || !w_ask_stat.present) begin
            w_plausible = 1'b1;
        end else if (r_inverted) begin
            w_plausible = !($signed(w_top_bid) < $signed(w_top_ask));
        end else begin
            w_plausible = !($signed(w_top_ask) < $signed(w_top_bid));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bid_present <= w_bid_stat.present;
            r_top_bid     <= w_top_bid;
            r_ask_present <= w_ask_stat.present;
            r_top_ask     <= w_top_ask;
            r_plausible   <= w_plausible;
            r_dropped     <= w_bid_stat.drop || w_ask_stat.drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bid_present  = r_bid_present;
    assign o_out.top_bid      = r_top_bid;
    assign o_out.ask_present  = r_ask_present;
    assign o_out.top_ask      = r_top_ask;
    assign o_out.plausible    = r_plausible;
    assign o_out.dropped_full = r_dropped;

endmodule

FILE: rtl/core/plbq_checker.sv
// port-level checks for the price level book top, attached by bind
// depends on plbq_pkg, price_level_book_best_quote_top
module plbq_checker import plbq_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_bid_present,
    input t_price i_top_bid,
    input logic   i_ask_present,
    input t_price i_top_ask,
    input logic   i_plausible,
    input logic   i_dropped_full
);

    // a quote beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("quote beat withdrawn before taken");

    // one update in flight: no beat right after a beat
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("update beat accepted while one is in flight");

    // absent side reads as zero price
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bid_present || i_top_bid == '0) &&
                        (i_ask_present || i_top_ask == '0))
        else $error("absent side with nonzero price");

    // an empty side can never cross the book
    a_empty_plausible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (!i_bid_present || !i_ask_present) |-> i_plausible)
        else $error("implausible quote with an empty side");

    // a refused level means its side is full, so not empty
    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped_full |-> i_bid_present || i_ask_present)
        else $error("drop flagged with both sides empty");

endmodule

bind price_level_book_best_quote_top plbq_checker u_plbq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_bid_present  (o_out.bid_present),
    .i_top_bid      (o_out.top_bid),
    .i_ask_present  (o_out.ask_present),
    .i_top_ask      (o_out.top_ask),
    .i_plausible    (o_out.plausible),
    .i_dropped_full (o_out.dropped_full)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// self-checking bench for price_level_book_best_quote_top: directed updates, then random ones
// depends on plbq_pkg, plbq_if and the book top; the quotes are predicted by a model kept here
module tb;
    import plbq_pkg::*;

    localparam int BOOK_DEPTH      = 64;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int NUM_ROWS        = 19;
    localparam int POOL_SIZE       = 96;

    // side codes and orientation values
    localparam logic SIDE_BID        = 1'b0;
    localparam logic SIDE_ASK        = 1'b1;
    localparam logic ORIENT_NORMAL   = 1'b0;
    localparam logic ORIENT_INVERTED = 1'b1;

    localparam t_price PX_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_price PX_MIN   = 64'sh8000_0000_0000_0000;
    localparam t_qty   QTY_FULL = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic   bid_present;
        t_price top_bid;
        logic   ask_present;
        t_price top_ask;
        logic   plausible;
        logic   dropped_full;
    } t_quote;

    // one directed update; the quote is only used where typed is set
    typedef struct {
        logic   side;
        t_price price;
        t_qty   qty;
        logic   typed;
        t_quote quote;
    } t_row;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    plbq_in_if  book_in ();
    plbq_out_if book_out ();

    price_level_book_best_quote_top #(
        .LEVELS_PER_SIDE(BOOK_DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (book_in),
        .o_out        (book_out)
    );

    // predicted book: the set of live prices per side plus the orientation bit
    // (quantities never show in a quote, so only the prices are kept)
    t_price bid_levels[$];
    t_price ask_levels[$];
    logic   book_inverted = ORIENT_NORMAL;

    t_quote pending_quotes[$];
    t_price price_pool [POOL_SIZE];

    int   sent_count     = 0;
    int   quotes_seen    = 0;
    int   mismatch_count = 0;
    int   burst_left     = 0;
    logic hold_armed     = 1'b0;
    logic hold_done      = 1'b0;

    // directed rows, starting from an empty book with normal orientation:
    // removal on an empty book, extremes of price and quantity, crossing both
    // ways, update in place, removal of an absent price on a live side,
    // negative and zero prices, touching quotes, and a walk back to empty
    t_row directed_rows [NUM_ROWS] = '{
        '{SIDE_BID, 64'sd100, 64'd0,    1'b1, '{0, 64'sd0, 0, 64'sd0, 1, 0}},
        '{SIDE_BID, 64'sd100, 64'd5,    1'b1, '{1, 64'sd100, 0, 64'sd0, 1, 0}},
        '{SIDE_ASK, 64'sd200, QTY_FULL, 1'b1, '{1, 64'sd100, 1, 64'sd200, 1, 0}},
        '{SIDE_BID, PX_MAX,   64'd1,    1'b1, '{1, PX_MAX, 1, 64'sd200, 0, 0}},
        '{SIDE_ASK, PX_MIN,   64'd1,    1'b1, '{1, PX_MAX, 1, PX_MIN, 0, 0}},
        '{SIDE_BID, PX_MAX,   64'd7,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_BID, PX_MAX,   64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, PX_MIN,   64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd300, 64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_BID, -64'sd1,  64'd3,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd100, 64'd1,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, -64'sd2,  64'd1,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd0,   64'd9,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, -64'sd2,  64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd0,   64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_BID, 64'sd100, 64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_BID, -64'sd1,  64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd100, 64'd0,    1'b0, '{0, 64'sd0, 0, 64'sd0, 0, 0}},
        '{SIDE_ASK, 64'sd200, 64'd0,    1'b1, '{0, 64'sd0, 0, 64'sd0, 1, 0}}
    };

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------- predictor

    // set one level on a side; returns 1 when a new price found the side full
    function automatic logic level_update(ref t_price levels[$], input t_price price,
                                          input t_qty qty);
        int hit;
        hit = -1;
        foreach (levels[i]) begin
            if (levels[i] == price) hit = i;
        end
        if (hit >= 0) begin
            if (qty == '0) levels.delete(hit);
            return 1'b0;
        end
        if (qty == '0) return 1'b0;
        if (levels.size() >= BOOK_DEPTH) return 1'b1;
        levels.push_back(price);
        return 1'b0;
    endfunction

    // signed highest or lowest live price of a side; price stays zero when empty
    function automatic logic side_best(input t_price levels[$], input logic want_high,
                                       output t_price best);
        logic found;
        found = 1'b0;
        best  = '0;
        foreach (levels[i]) begin
            if (!found || (want_high ? levels[i] > best : levels[i] < best)) begin
                best  = levels[i];
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic t_quote book_apply(input logic side, input t_price price,
                                          input t_qty qty);
        t_quote q;
        if (side == SIDE_ASK) q.dropped_full = level_update(ask_levels, price, qty);
        else                  q.dropped_full = level_update(bid_levels, price, qty);
        // normal book: highest bid, lowest ask; inverted book: the opposite
        q.bid_present = side_best(bid_levels, !book_inverted, q.top_bid);
        q.ask_present = side_best(ask_levels, book_inverted, q.top_ask);
        if (!q.bid_present || !q.ask_present) q.plausible = 1'b1;
        else if (book_inverted)               q.plausible = (q.top_bid >= q.top_ask);
        else                                  q.plausible = (q.top_bid <= q.top_ask);
        return q;
    endfunction

    // ---------------------------------------------------------------- quote check

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // every quote beat is matched against the oldest prediction
    always @(posedge clk) begin : quote_check
        t_quote want;
        if (rst_n && book_out.valid && book_out.ready) begin
            quotes_seen++;
            if (pending_quotes.size() == 0) begin
                $error("quote beat with no update waiting for it");
                mismatch_count++;
            end else begin
                want = pending_quotes.pop_front();
                check_field("bid_present", 64'(want.bid_present), 64'(book_out.bid_present));
                check_field("top_bid", want.top_bid, book_out.top_bid);
                check_field("ask_present", 64'(want.ask_present), 64'(book_out.ask_present));
                check_field("top_ask", want.top_ask, book_out.top_ask);
                check_field("plausible", 64'(want.plausible), 64'(book_out.plausible));
                check_field("dropped_full", 64'(want.dropped_full),
                            64'(book_out.dropped_full));
            end
        end
    end

    // ---------------------------------------------------------------- quote sink

    // mostly a random per-cycle stall, sometimes a clean stretch, and once
    // a long hold-off so the block fills up and backs up the update channel
    initial begin : quote_sink
        book_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_armed && !hold_done) begin
                book_out.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                book_out.ready <= 1'b1;
                repeat ($urandom_range(16, 64)) @(posedge clk);
            end else begin
                book_out.ready <= ($urandom_range(0, 3) != 0);
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------- update source

    function automatic t_price rand_price();
        return t_price'({$urandom(), $urandom()});
    endfunction

    function automatic t_qty rand_live_qty();
        t_qty q;
        q = ($urandom_range(0, 1) != 0) ? t_qty'({$urandom(), $urandom()})
                                        : t_qty'($urandom_range(1, 1000));
        if (q == '0) q = 64'd1;
        return q;
    endfunction

    // valid drops with junk on the payload
    task automatic idle_cycles(input int n);
        book_in.valid    <= 1'b0;
        book_in.side     <= 1'($urandom_range(0, 1));
        book_in.price    <= rand_price();
        book_in.quantity <= {$urandom(), $urandom()};
        repeat (n) @(posedge clk);
    endtask

    // bursts of random length with random gaps, some gaps zero
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 8));
        end
    endtask

    // offer one update beat, hold it until taken, then log its quote
    task automatic offer_update(input logic side, input t_price price, input t_qty qty,
                                input logic typed, input t_quote typed_quote);
        t_quote predicted;
        book_in.valid    <= 1'b1;
        book_in.side     <= side;
        book_in.price    <= price;
        book_in.quantity <= qty;
        do @(posedge clk); while (!book_in.ready);
        sent_count++;
        predicted = book_apply(side, price, qty);
        pending_quotes.push_back(typed ? typed_quote : predicted);
        pace_sender();
    endtask

    task automatic offer_random(input logic side, input t_price price, input t_qty qty);
        t_quote unused;
        unused = '{0, 64'sd0, 0, 64'sd0, 0, 0};
        offer_update(side, price, qty, 1'b0, unused);
    endtask

    // stop offering and wait until every quote is back
    task automatic wait_quotes_drained();
        idle_cycles(1);
        while (pending_quotes.size() != 0) @(posedge clk);
    endtask

    // orientation only changes on an idle block
    task automatic write_orientation(input logic orient);
        wait_quotes_drained();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= orient;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'($urandom_range(0, 1));
        book_inverted = orient;
    endtask

    // prices clustered around a random center, plus extremes, small values
    // and a few wild ones, so updates keep hitting live levels
    task automatic build_price_pool();
        t_price center;
        int     offset;
        center = t_price'($signed($urandom()));
        for (int i = 0; i < POOL_SIZE; i++) begin
            offset = int'($urandom_range(0, 40)) - 20;
            if (i < 60)      price_pool[i] = center + t_price'(offset * 100);
            else if (i < 80) price_pool[i] = rand_price();
            else if (i < 84) price_pool[i] = PX_MAX - t_price'(i - 80);
            else if (i < 88) price_pool[i] = PX_MIN + t_price'(i - 84);
            else             price_pool[i] = t_price'(i - 92);
        end
    endtask

    // push a side past full, touch live levels while full, then thin it out
    task automatic fill_side(input logic side);
        t_price held[$];
        repeat ($urandom_range(66, 72)) offer_random(side, rand_price(), rand_live_qty());
        repeat (8) begin
            if (side == SIDE_ASK) held = ask_levels;
            else                  held = bid_levels;
            if (held.size() != 0)
                offer_random(side, held[$urandom_range(0, held.size() - 1)],
                             rand_live_qty());
        end
        repeat (24) begin
            if (side == SIDE_ASK) held = ask_levels;
            else                  held = bid_levels;
            if (held.size() != 0)
                offer_random(side, held[$urandom_range(0, held.size() - 1)], '0);
        end
    endtask

    task automatic pool_burst();
        repeat ($urandom_range(10, 30)) begin
            offer_random(1'($urandom_range(0, 1)),
                         price_pool[$urandom_range(0, POOL_SIZE - 1)],
                         ($urandom_range(0, 99) < 35) ? t_qty'(0) : rand_live_qty());
        end
    endtask

    // full-range noise, half of it removals that mostly miss
    task automatic noise_burst();
        repeat ($urandom_range(3, 10)) begin
            offer_random(1'($urandom_range(0, 1)), rand_price(),
                         ($urandom_range(0, 1) != 0) ? t_qty'(0)
                                                     : t_qty'({$urandom(), $urandom()}));
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        int   phase_start;
        int   phase_end;
        int   pick;
        logic paused;
        paused           = 1'b0;
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= 1'b0;
        book_in.valid    <= 1'b0;
        book_in.side     <= SIDE_BID;
        book_in.price    <= '0;
        book_in.quantity <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run on the reset orientation
        foreach (directed_rows[i]) begin
            offer_update(directed_rows[i].side, directed_rows[i].price, directed_rows[i].qty,
                         directed_rows[i].typed, directed_rows[i].quote);
        end

        // random phases alternate the orientation; the book carries over,
        // so each flip also re-reads a live book the other way round
        for (int phase = 0; phase < 4; phase++) begin
            write_orientation((phase % 2 == 0) ? ORIENT_INVERTED : ORIENT_NORMAL);
            build_price_pool();
            phase_start = sent_count;
            phase_end   = sent_count + ITEMS_PER_PHASE;
            if (phase % 2 == 0) fill_side(1'($urandom_range(0, 1)));
            while (sent_count < phase_end) begin
                // one full pause of the sender mid-run
                if (phase == 1 && !paused && sent_count >= phase_start + 100) begin
                    wait_quotes_drained();
                    paused = 1'b1;
                end
                // let the sink start its long hold while beats keep coming
                if (phase == 2 && sent_count >= phase_start + 60) hold_armed = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 4)       fill_side(1'($urandom_range(0, 1)));
                else if (pick < 85) pool_burst();
                else                noise_burst();
            end
        end

        wait_quotes_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("price_level_book_best_quote_top test passed");
        end else begin
            $display("price_level_book_best_quote_top test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("price_level_book_best_quote_top test failed");
        $finish;
    end

endmodule
